FILE: sv/sfrr_pkg.sv
package sfrr_pkg;

    localparam int MAX_FRAME_DEF = 11;

    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;
    localparam logic [7:0] CMD_POLL   = 8'h04;
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] OPEN_BYTE  = 8'h28;
    localparam logic [7:0] CLOSE_BYTE = 8'h29;
    localparam logic [7:0] DEV_BYTE   = 8'h01;
    localparam logic [7:0] FUNC_BYTE  = 8'h03;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    localparam int LEN_POS = 3;
    localparam int CMD_POS = 4;
    localparam int HDR_LEN = 5;

    localparam int OUT_LEN = 17;
    localparam int OIDX_W  = $clog2(OUT_LEN);
    localparam logic [OIDX_W-1:0] SUM_FIRST = OIDX_W'(3);
    localparam logic [OIDX_W-1:0] SUM_LAST  = OIDX_W'(12);
    localparam logic [OIDX_W-1:0] OUT_LAST  = OIDX_W'(OUT_LEN - 1);

    localparam int   PADDR_W        = 3;
    localparam logic REG_POLL_INDEX = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SUM,
        SEQ_EMIT
    } t_seq_state;

    typedef struct packed {
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] s3;
        logic [7:0] s6;
        logic [7:0] s7;
    } t_frame_fields;

    typedef struct packed {
        logic          emit;
        t_frame_fields fields;
    } t_parse_out;

    function automatic logic [7:0] frame_byte(
        input logic [OIDX_W-1:0] idx,
        input t_frame_fields     f,
        input logic [7:0]        poll,
        input logic [15:0]       sum
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = OPEN_BYTE;
            5'd1:    b = FLAG_BYTE;
            5'd2:    b = FLAG_BYTE;
            5'd3:    b = SYNC_BYTE;
            5'd4:    b = f.s1;
            5'd5:    b = f.s2;
            5'd6:    b = f.s3;
            5'd7:    b = DEV_BYTE;
            5'd8:    b = FUNC_BYTE;
            5'd9:    b = poll;
            5'd10:   b = ZERO_BYTE;
            5'd11:   b = f.s6;
            5'd12:   b = f.s7;
            5'd13:   b = sum[7:0];
            5'd14:   b = sum[15:8];
            5'd15:   b = END_BYTE;
            5'd16:   b = CLOSE_BYTE;
            default: b = ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/sfrr_parser.sv
module sfrr_parser #(
    parameter int MAX_FRAME = sfrr_pkg::MAX_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_rx_byte,
    output sfrr_pkg::t_parse_out o_status
);
    import sfrr_pkg::*;

    localparam int DEPTH  = MAX_FRAME + 1;
    localparam int FILL_W = $clog2(MAX_FRAME + 2);
    localparam int SIDX_W = $clog2(DEPTH);
    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(MAX_FRAME);
    localparam logic [FILL_W-1:0] FILL_DEPTH = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_HDR   = FILL_W'(HDR_LEN);
    localparam logic [7:0]        LEN_MAX    = 8'(MAX_FRAME - 2);

    t_phase            r_phase;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_store [DEPTH];

    t_phase            w_phase;
    logic [FILL_W-1:0] w_fill;
    logic [7:0]        w_store [DEPTH];
    logic              w_put;
    logic              w_emit;
    logic              w_clr;

    always_comb begin
        w_phase = r_phase;
        w_fill  = r_fill;
        w_store = r_store;
        w_emit  = 1'b0;
        w_clr   = 1'b0;

        // A frame that ran past the store starts over, and this byte is hunted afresh.
        if (w_fill > FILL_MAX) begin
            w_phase = PH_HUNT;
            w_fill  = '0;
            for (int k = 0; k < DEPTH; k++) begin
                w_store[k] = '0;
            end
        end

        w_put = ((w_phase == PH_HUNT) && (i_rx_byte == SYNC_BYTE)) ||
                (w_phase == PH_HEAD) || (w_phase == PH_BODY);

        if (w_put) begin
            if (w_fill < FILL_DEPTH) begin
                w_store[w_fill[SIDX_W-1:0]] = i_rx_byte;
            end
            w_fill = w_fill + FILL_W'(1);
        end

        case (w_phase)
            PH_HUNT: begin
                if (w_put) begin
                    w_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (w_fill >= FILL_HDR) begin
                    if (w_store[LEN_POS] > LEN_MAX) begin
                        w_phase = PH_HUNT;
                        w_fill  = '0;
                        for (int k = 0; k <= LEN_POS; k++) begin
                            w_store[k] = '0;
                        end
                    end else begin
                        w_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if ((i_rx_byte == END_BYTE) &&
                    (9'(w_fill) == (9'(w_store[LEN_POS]) + 9'd2))) begin
                    w_emit = (w_store[CMD_POS] == CMD_POLL);
                    w_clr  = 1'b1;
                end
            end
            default: begin
                w_clr = 1'b1;
            end
        endcase

        o_status.emit      = w_emit;
        o_status.fields.s1 = w_store[1];
        o_status.fields.s2 = w_store[2];
        o_status.fields.s3 = w_store[3];
        o_status.fields.s6 = w_store[6];
        o_status.fields.s7 = w_store[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_en) begin
            if (w_clr) begin
                r_phase <= PH_HUNT;
                r_fill  <= '0;
                for (int k = 0; k < DEPTH; k++) begin
                    r_store[k] <= '0;
                end
            end else begin
                r_phase <= w_phase;
                r_fill  <= w_fill;
                r_store <= w_store;
            end
        end
    end

endmodule

FILE: sv/serial_frame_receiver_reformatter_top.sv
// A byte that completes no command frame is taken without raising o_stall.
// A byte that completes a command frame starts a checksum over output bytes 3 to 12 on one
// shared 16-bit adder, then the 17 output bytes are emitted.
// o_stall stays high until the last output byte has been loaded into the output register.
// Reset is synchronous and active low; it clears the sequencer, the frame store, the
// parser state, the output valid flag and the poll index.
module serial_frame_receiver_reformatter_top #(
    parameter int MAX_FRAME = sfrr_pkg::MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfrr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sfrr_pkg::*;

    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [OIDX_W-1:0] r_idx;
    logic [15:0]       r_sum;
    t_frame_fields     r_fields;
    logic [7:0]        r_poll_index;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    t_parse_out        w_parse;
    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic              w_cfg_sel;
    logic              w_cfg_wr;
    logic [7:0]        w_frame_byte;

    sfrr_parser #(
        .MAX_FRAME(MAX_FRAME)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_rx_byte(i_rx_byte),
        .o_status (w_parse)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_cfg_sel = (paddr[PADDR_W-1] == REG_POLL_INDEX);
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_sel;
    assign prdata    = w_cfg_sel ? {24'd0, r_poll_index} : 32'd0;
    assign pready    = 1'b1;

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (w_accept && w_parse.emit) begin
                    n_state = SEQ_SUM;
                end
            end
            SEQ_SUM: begin
                if (r_idx == SUM_LAST) begin
                    n_state = SEQ_EMIT;
                end
            end
            SEQ_EMIT: begin
                if (w_out_free && (r_idx == OUT_LAST)) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall      = (r_state != SEQ_IDLE);
        w_load       = (r_state == SEQ_EMIT) && w_out_free;
        w_frame_byte = frame_byte(r_idx, r_fields, r_poll_index, r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SEQ_IDLE;
            r_idx        <= '0;
            r_poll_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                r_poll_index <= pwdata[7:0];
            end

            case (r_state)
                SEQ_IDLE: begin
                    if (w_accept && w_parse.emit) begin
                        r_fields <= w_parse.fields;
                        r_sum    <= '0;
                        r_idx    <= SUM_FIRST;
                    end
                end
                SEQ_SUM: begin
                    r_sum <= r_sum + 16'(w_frame_byte);
                    r_idx <= (r_idx == SUM_LAST) ? '0 : r_idx + OIDX_W'(1);
                end
                SEQ_EMIT: begin
                    if (w_load) begin
                        r_idx <= r_idx + OIDX_W'(1);
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= w_frame_byte;
                r_out_last  <= (r_idx == OUT_LAST);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/sfrr_checker.sv
module sfrr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Input is held off while a frame is still being sent, up to its final byte.
    a_busy_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open during a frame");

    // Once the final byte is taken, nothing follows until a new input transaction.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid)
        else $error("byte after end of frame");

    // A stalled output transaction holds its payload.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output changed");

endmodule

bind serial_frame_receiver_reformatter_top sfrr_checker u_sfrr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_out_byte(o_out_byte),
    .o_last    (o_last)
);

FILE: tb/serial_frame_receiver_reformatter_top_tb.sv
`timescale 1ns / 1ps

module serial_frame_receiver_reformatter_top_tb;
    import sfrr_pkg::*;

    localparam int MAX_FRAME     = MAX_FRAME_DEF;
    localparam int STORE_DEPTH   = MAX_FRAME + 1;
    localparam int FROM_MODEL    = -1;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 16;
    localparam logic [PADDR_W-1:0] POLL_INDEX_ADDR = PADDR_W'(4 * REG_POLL_INDEX);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] rx;
        int         typed_replies;
    } dir_row_t;

    // Stray bytes, an oversized length, a short poll frame, then a body that
    // overflows the store so that the following start byte is taken afresh.
    localparam dir_row_t DIRECTED_ROWS [26] = '{
        '{8'h00, 0},          '{8'hFF, 0},
        '{8'hAA, FROM_MODEL}, '{8'hFF, FROM_MODEL}, '{8'h00, FROM_MODEL},
        '{8'hFF, FROM_MODEL}, '{8'h04, 0},
        '{8'hAA, FROM_MODEL}, '{8'hFF, FROM_MODEL}, '{8'h00, FROM_MODEL},
        '{8'h04, FROM_MODEL}, '{8'h04, FROM_MODEL}, '{8'h55, OUT_LEN},
        '{8'hAA, FROM_MODEL}, '{8'h80, FROM_MODEL}, '{8'h7F, FROM_MODEL},
        '{8'h09, FROM_MODEL}, '{8'h04, FROM_MODEL}, '{8'h55, FROM_MODEL},
        '{8'hFF, FROM_MODEL}, '{8'h00, FROM_MODEL}, '{8'h01, FROM_MODEL},
        '{8'h02, FROM_MODEL}, '{8'h03, FROM_MODEL}, '{8'h33, 0},
        '{8'hAA, FROM_MODEL}
    };

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall   = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    t_phase      rx_phase;
    int          rx_fill;
    logic [7:0]  rx_store [STORE_DEPTH];
    logic [7:0]  poll_index_now;
    out_beat_t   beats_due [$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic stall_now   = 1'b0;
    bit   tx_calm     = 1'b0;
    bit   rx_calm     = 1'b0;

    serial_frame_receiver_reformatter_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_frame();
        rx_phase = PH_HUNT;
        rx_fill  = 0;
        foreach (rx_store[k]) rx_store[k] = 8'h00;
    endfunction

    function automatic void store_rx(input logic [7:0] b);
        if (rx_fill < STORE_DEPTH) begin
            rx_store[rx_fill] = b;
        end
        rx_fill++;
    endfunction

    function automatic int track_rx_byte(input logic [7:0] b);
        logic [7:0]  beat [OUT_LEN];
        logic [15:0] sum;
        int          n;
        n   = 0;
        sum = 16'h0;
        if (rx_fill > MAX_FRAME) begin
            clear_frame();
        end
        case (rx_phase)
            PH_HUNT: begin
                if (b == SYNC_BYTE) begin
                    rx_phase = PH_HEAD;
                    store_rx(b);
                end
            end
            PH_HEAD: begin
                store_rx(b);
                if (rx_fill >= HDR_LEN) begin
                    if (rx_store[LEN_POS] > MAX_FRAME - 2) begin
                        rx_phase = PH_HUNT;
                        rx_fill  = 0;
                        for (int k = 0; k <= LEN_POS; k++) rx_store[k] = 8'h00;
                    end else begin
                        rx_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                store_rx(b);
                if (b == END_BYTE && rx_fill == rx_store[LEN_POS] + 2) begin
                    if (rx_store[CMD_POS] == CMD_POLL) begin
                        beat[0]  = OPEN_BYTE;
                        beat[1]  = FLAG_BYTE;
                        beat[2]  = FLAG_BYTE;
                        beat[3]  = SYNC_BYTE;
                        beat[4]  = rx_store[1];
                        beat[5]  = rx_store[2];
                        beat[6]  = rx_store[LEN_POS];
                        beat[7]  = DEV_BYTE;
                        beat[8]  = FUNC_BYTE;
                        beat[9]  = poll_index_now;
                        beat[10] = ZERO_BYTE;
                        beat[11] = rx_store[6];
                        beat[12] = rx_store[7];
                        for (int k = 3; k <= 12; k++) sum = sum + 16'(beat[k]);
                        beat[13] = sum[7:0];
                        beat[14] = sum[15:8];
                        beat[15] = END_BYTE;
                        beat[16] = CLOSE_BYTE;
                        for (int k = 0; k < OUT_LEN; k++) begin
                            beats_due.push_back('{beat[k], k == OUT_LEN - 1});
                        end
                        n = OUT_LEN;
                    end
                    clear_frame();
                end
            end
            default: begin
                clear_frame();
            end
        endcase
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) begin
            return 0;
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, output int n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        n = track_rx_byte(b);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_poll_index(input logic [31:0] want);
        logic [31:0] got;
        apb_read(POLL_INDEX_ADDR, got);
        if (got !== want) begin
            $display("%0t: poll_index read expected %h actual %h", $time, want, got);
            fail_count++;
        end
    endtask

    task automatic set_poll_index(input logic [7:0] v);
        apb_write(POLL_INDEX_ADDR, {24'h0, v});
        poll_index_now = v;
        check_poll_index({24'h0, v});
    endtask

    task automatic wait_idle();
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_frame(output int items, output int replies);
        int         kind;
        int         len;
        int         n;
        logic [7:0] b;
        logic [7:0] head [HDR_LEN];
        items   = 0;
        replies = 0;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom);
                if (b == SYNC_BYTE) begin
                    b = END_BYTE;
                end
                send_byte(b, n);
                replies += n;
                items++;
            end
        end else begin
            if (kind < 20) begin
                len = $urandom_range(MAX_FRAME - 1, 255);
            end else if (kind < 30) begin
                len = $urandom_range(0, MAX_FRAME - 2);
            end else begin
                len = $urandom_range(4, MAX_FRAME - 2);
            end
            head[0]       = SYNC_BYTE;
            head[1]       = 8'($urandom);
            head[2]       = 8'($urandom);
            head[LEN_POS] = 8'(len);
            head[CMD_POS] = ($urandom_range(0, 9) < 7) ? CMD_POLL : 8'($urandom);
            for (int k = 0; k < HDR_LEN; k++) begin
                send_byte(head[k], n);
                replies += n;
                items++;
            end
            if (kind >= 20 && kind < 30) begin
                repeat (MAX_FRAME - 4) begin
                    send_byte(8'($urandom), n);
                    replies += n;
                    items++;
                end
            end else if (kind >= 30) begin
                for (int k = 0; k < len - 3; k++) begin
                    b = (k == len - 4) ? END_BYTE : 8'($urandom);
                    send_byte(b, n);
                    replies += n;
                    items++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : out_monitor
        out_beat_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (beats_due.size() == 0) begin
                $display("%0t: unexpected output byte %h last %b", $time, o_out_byte, o_last);
                fail_count++;
            end else begin
                want = beats_due.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.data, o_out_byte);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_now = rx_calm ? 1'b0 : ($urandom_range(0, 2) == 0);
            if (stall_now) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end else begin
                stall_left = $urandom_range(1, 12);
            end
        end
        stall_left--;
        i_stall <= stall_now;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("serial_frame_receiver_reformatter_top regression: fail");
            $finish;
        end
    end

    initial begin
        int         n;
        int         items;
        int         replies;
        int         phase_items;
        int         phase_replies;
        logic [7:0] poll_plan [4];

        clear_frame();
        poll_index_now = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_poll_index(32'h0);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
            send_byte(DIRECTED_ROWS[r].rx, n);
            if (DIRECTED_ROWS[r].typed_replies != FROM_MODEL &&
                n != DIRECTED_ROWS[r].typed_replies) begin
                $display("%0t: row %0d expected %0d output bytes, actual %0d",
                         $time, r, DIRECTED_ROWS[r].typed_replies, n);
                fail_count++;
            end
        end
        i_valid <= 1'b0;

        poll_plan[0] = 8'hFF;
        poll_plan[1] = 8'($urandom);
        poll_plan[2] = 8'h00;
        poll_plan[3] = 8'($urandom);
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            set_poll_index(poll_plan[p]);
            phase_items   = 0;
            phase_replies = 0;
            while (phase_items < PHASE_ITEMS || phase_replies < OUT_LEN) begin
                send_random_frame(items, replies);
                phase_items   += items;
                phase_replies += replies;
            end
            i_valid <= 1'b0;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("serial_frame_receiver_reformatter_top regression: pass");
        end else begin
            $display("serial_frame_receiver_reformatter_top regression: fail");
        end
        $finish;
    end

endmodule
